// ===== hdl/bhpq_pkg.sv =====
// shared constants and codes of the binary heap priority queue
`default_nettype none

package bhpq_pkg;

    // defaults for the top-level parameters
    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed field widths of the request and response words
    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_HEAP_ORDER = 1'b0;   // word index of the order register

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_READ = 2'd2
    } t_func;

    // response status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/bhpq_if.sv =====
// request and response channel interfaces of the heap queue
`default_nettype none

interface bhpq_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic signed [31:0]   key;
    logic [9:0]           slot;

    modport source (output valid, output func, output key, output slot, input ready);
    modport sink   (input valid, input func, input key, input slot, output ready);
endinterface

interface bhpq_rsp_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   root_key;
    logic [10:0]          entry_count;
    logic signed [31:0]   slot_data;
    logic [1:0]           status;

    modport source (output valid, output root_key, output entry_count, output slot_data,
                    output status, input ready);
    modport sink   (input valid, input root_key, input entry_count, input slot_data,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/bhpq_ram.sv =====
// heap storage: one write port, two registered read ports
`default_nettype none

module bhpq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered, updated only while i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/binary_heap_priority_queue_top.sv =====
// binary heap priority queue: request decode, sift sequencer and response register
//
//  channel   dir   handshake        word
//  i_req     in    valid/ready      func, key, slot
//  o_rsp     out   valid/ready      root_key, entry_count, slot_data, status
//  apb       in    psel/penable     heap_order register at byte address 0
//
// one word at a time; each sift level is a memory read, then a compare and write
// back. a push sifts up from the new last slot, a pop moves the last key to the
// root and sifts it down unless it was the only one, a read fetches one slot, and
// flagged words go straight to the response register. the next word is accepted
// the cycle after the result loads, even while it waits; a second result then
// stalls in S_OUT. sync active-low reset empties the heap.
`default_nettype none

module binary_heap_priority_queue_top #(
    parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    bhpq_req_if.sink                          i_req,
    bhpq_rsp_if.source                        o_rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bhpq_pkg::PADDR_W-1:0] paddr,
    input  wire logic [bhpq_pkg::PDATA_W-1:0] pwdata,
    output logic      [bhpq_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    import bhpq_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = AW + 2;
    localparam int XW  = (KEY_WIDTH > KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int SCW = (CW > SLOT_W) ? CW : SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_GET,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_SLOT_RD,
        S_SLOT_GET,
        S_PUT,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic                        r_order;
    logic [CW-1:0]               r_count;
    logic [AW-1:0]               r_pos;
    logic [SLOT_W-1:0]           r_slot;
    logic signed [KEY_WIDTH-1:0] r_k;
    logic signed [KEY_WIDTH-1:0] r_root;
    logic signed [KEY_WIDTH-1:0] r_data;
    t_status                     r_status;

    logic                        r_ovalid;
    logic signed [KEY_W-1:0]     r_o_root;
    logic [COUNT_W-1:0]          r_o_count;
    logic signed [KEY_W-1:0]     r_o_data;
    t_status                     r_o_status;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic signed [KEY_WIDTH-1:0] w_wdata;
    logic                        w_re;
    logic [AW-1:0]               w_raddr_a;
    logic [AW-1:0]               w_raddr_b;
    logic signed [KEY_WIDTH-1:0] w_rd_a;
    logic signed [KEY_WIDTH-1:0] w_rd_b;

    logic [AW-1:0]               w_parent;
    logic [PW-1:0]               w_lc;
    logic [PW-1:0]               w_rc;
    logic                        w_lc_ok;
    logic                        w_rc_ok;
    logic                        w_take_l;
    logic                        w_take_r;
    logic signed [KEY_WIDTH-1:0] w_best_l;
    logic                        w_up_move;
    logic                        w_dn_move;
    logic signed [KEY_WIDTH-1:0] w_dn_val;
    logic [AW-1:0]               w_dn_pos;
    logic signed [KEY_WIDTH-1:0] w_key_ext;
    logic                        w_accept;
    logic                        w_cfg_wr;

    // a belongs strictly nearer the root than b
    function automatic logic ahead(logic order, logic signed [KEY_WIDTH-1:0] a,
                                   logic signed [KEY_WIDTH-1:0] b);
        return order ? (a > b) : (a < b);
    endfunction

    // low 32 bits of the sign-extended key
    function automatic logic [KEY_W-1:0] to_out(logic signed [KEY_WIDTH-1:0] v);
        logic signed [XW-1:0] w;
        w = XW'(v);
        return w[KEY_W-1:0];
    endfunction

    bhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // handshakes and configuration port
    assign w_accept     = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_cfg_wr     = psel && penable && pwrite && pready;
    assign pready       = 1'b1;
    assign prdata       = (paddr[PADDR_W-1] == REG_HEAP_ORDER) ?
                          {{(PDATA_W-1){1'b0}}, r_order} : '0;
    assign w_key_ext    = KEY_WIDTH'(XW'(i_req.key));

    // response word
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.root_key    = r_o_root;
    assign o_rsp.entry_count = r_o_count;
    assign o_rsp.slot_data   = r_o_data;
    assign o_rsp.status      = r_o_status;

    // neighbor addresses
    assign w_parent = (r_pos - AW'(1)) >> 1;
    assign w_lc     = {1'b0, r_pos, 1'b1};
    assign w_rc     = {1'b0, r_pos, 1'b0} + PW'(2);
    assign w_lc_ok  = w_lc < PW'(r_count);
    assign w_rc_ok  = w_rc < PW'(r_count);

    // sift decisions; left child wins a tie
    assign w_up_move = ahead(r_order, r_k, w_rd_a);
    assign w_take_l  = w_lc_ok && ahead(r_order, w_rd_a, r_k);
    assign w_best_l  = w_take_l ? w_rd_a : r_k;
    assign w_take_r  = w_rc_ok && ahead(r_order, w_rd_b, w_best_l);
    assign w_dn_move = w_take_l || w_take_r;
    assign w_dn_val  = w_take_r ? w_rd_b : w_rd_a;
    assign w_dn_pos  = w_take_r ? w_rc[AW-1:0] : w_lc[AW-1:0];

    // memory port control
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_k;
        w_re      = 1'b0;
        w_raddr_a = '0;
        w_raddr_b = '0;
        unique case (r_state)
            S_POP_RD: begin
                w_re      = 1'b1;
                w_raddr_a = AW'(r_count - CW'(1));
            end
            S_UP_RD: begin
                w_re      = 1'b1;
                w_raddr_a = w_parent;
            end
            S_DN_RD: begin
                w_re      = 1'b1;
                w_raddr_a = w_lc[AW-1:0];
                w_raddr_b = w_rc[AW-1:0];
            end
            S_SLOT_RD: begin
                w_re      = 1'b1;
                w_raddr_a = AW'(r_slot);
            end
            S_UP_CMP: begin
                w_we    = w_up_move;
                w_wdata = w_rd_a;
            end
            S_DN_CMP: begin
                w_we    = w_dn_move;
                w_wdata = w_dn_val;
            end
            S_PUT: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer, root copy and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_order  <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr[PADDR_W-1] == REG_HEAP_ORDER) begin
                r_order <= pwdata[0];
            end
            if (w_we && w_waddr == '0) begin
                r_root <= w_wdata;
            end
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= ST_OK;
                        r_data   <= '0;
                        r_k      <= w_key_ext;
                        r_slot   <= i_req.slot;
                        r_pos    <= '0;
                        unique case (t_func'(i_req.func))
                            FN_PUSH: begin
                                if (r_count == CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_pos   <= AW'(r_count);
                                    r_count <= r_count + CW'(1);
                                    r_state <= (r_count == '0) ? S_PUT : S_UP_RD;
                                end
                            end
                            FN_POP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_POP_RD;
                                end
                            end
                            FN_READ: begin
                                if (SCW'(i_req.slot) >= SCW'(r_count)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_SLOT_RD;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_GET;
                end
                S_POP_GET: begin
                    // last entry becomes the moving key, hole at the root
                    r_k     <= w_rd_a;
                    r_count <= r_count - CW'(1);
                    r_state <= (r_count == CW'(1)) ? S_OUT : S_DN_RD;
                end
                S_UP_RD: begin
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (w_up_move) begin
                        r_pos   <= w_parent;
                        r_state <= (w_parent == '0) ? S_PUT : S_UP_RD;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_DN_RD: begin
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (w_dn_move) begin
                        r_pos   <= w_dn_pos;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_SLOT_RD: begin
                    r_state <= S_SLOT_GET;
                end
                S_SLOT_GET: begin
                    r_data  <= w_rd_a;
                    r_state <= S_OUT;
                end
                S_PUT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_root   <= (r_count != '0) ? to_out(r_root) : '0;
                        r_o_count  <= COUNT_W'(r_count);
                        r_o_data   <= to_out(r_data);
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bhpq_checker.sv =====
// port-level checks of the heap queue, bound to the top level
`default_nettype none

module bhpq_checker #(
    parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_rsp_valid,
    input wire logic                      i_rsp_ready,
    input wire logic signed [31:0]        i_root_key,
    input wire logic [10:0]               i_entry_count,
    input wire logic signed [31:0]        i_slot_data,
    input wire logic [1:0]                i_status
);

    import bhpq_pkg::*;

    // count never goes past capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (int'(i_entry_count) <= CAPACITY))
        else $error("entry count above capacity");

    // an empty heap reports a zero root
    a_empty_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_entry_count == '0) |-> (i_root_key == '0))
        else $error("nonzero root on empty heap");

    // a full push is flagged only when the heap is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == ST_FULL) |-> (i_entry_count == 11'(CAPACITY)))
        else $error("full status with free space");

    // an empty pop is flagged only on an empty heap, with no read data
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == ST_EMPTY) |->
        (i_entry_count == '0 && i_slot_data == '0))
        else $error("empty status on non-empty heap");

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_root_key) && $stable(i_entry_count) &&
         $stable(i_slot_data) && $stable(i_status)))
        else $error("response word changed while stalled");

endmodule

bind binary_heap_priority_queue_top bhpq_checker #(
    .CAPACITY (CAPACITY)
) u_bhpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_root_key    (o_rsp.root_key),
    .i_entry_count (o_rsp.entry_count),
    .i_slot_data   (o_rsp.slot_data),
    .i_status      (o_rsp.status)
);

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench of the binary heap priority queue: random and directed words
`timescale 1ns / 1ps

module tb;
    import bhpq_pkg::*;

    localparam int HEAP_DEPTH     = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 100;
    localparam int HOLD_AT_WORD   = 200;
    localparam logic [FUNC_W-1:0]   FN_NOP   = 2'd3;   // unused code, must change nothing
    localparam logic [SLOT_W-1:0]   SLOT_TOP = 10'd1023;
    localparam logic signed [31:0]  KEY_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0]  KEY_MIN  = 32'sh8000_0000;
    localparam logic [PADDR_W-1:0]  ORDER_ADDR = {REG_HEAP_ORDER, 2'b00};

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic signed [31:0] key;
        logic [SLOT_W-1:0]  slot;
    } heap_word_t;

    typedef struct {
        logic signed [31:0] root_key;
        logic [COUNT_W-1:0] entry_count;
        logic signed [31:0] slot_data;
        t_status            status;
    } heap_result_t;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    bhpq_req_if req_ch ();
    bhpq_rsp_if rsp_ch ();

    binary_heap_priority_queue_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the heap
    logic signed [31:0] shadow_heap [0:HEAP_DEPTH-1];
    int unsigned        shadow_len;
    bit                 shadow_max;

    heap_word_t   pending_words [$];
    heap_result_t heap_expect [$];
    heap_word_t   drive_word;

    int  gen_len;
    int  mismatches;
    int  words_in;
    int  words_out;
    int  peak_len;
    int  status_hits [4];
    bit  calm;
    bit  req_fire;
    int  send_gap;
    int  hold_left;
    bit  long_hold_done;
    int  quiet_cycles;

    // true when a belongs strictly nearer the root than b
    function automatic bit outranks(input logic signed [31:0] a, input logic signed [31:0] b);
        return shadow_max ? (a > b) : (a < b);
    endfunction

    // apply one request word to the shadow heap, return the result word it causes
    function automatic heap_result_t heap_apply(input logic [FUNC_W-1:0] func,
                                                input logic signed [31:0] key,
                                                input logic [SLOT_W-1:0] slot);
        heap_result_t       res;
        int unsigned        pos;
        int unsigned        up;
        int unsigned        lc;
        int unsigned        rc;
        int unsigned        best;
        logic signed [31:0] tmp;
        bit                 done;
        res.slot_data = '0;
        res.status    = ST_OK;
        if (func == FN_PUSH) begin
            if (shadow_len >= HEAP_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_heap[shadow_len] = key;
                pos = shadow_len;
                shadow_len++;
                done = 0;
                while (pos != 0 && !done) begin
                    up = (pos - 1) / 2;
                    if (!outranks(shadow_heap[pos], shadow_heap[up])) begin
                        done = 1;
                    end else begin
                        tmp = shadow_heap[pos];
                        shadow_heap[pos] = shadow_heap[up];
                        shadow_heap[up] = tmp;
                        pos = up;
                    end
                end
            end
        end else if (func == FN_POP) begin
            if (shadow_len == 0) begin
                res.status = ST_EMPTY;
            end else begin
                shadow_heap[0] = shadow_heap[shadow_len - 1];
                shadow_len--;
                pos = 0;
                done = 0;
                while (!done) begin
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    best = pos;
                    // left child wins a tie between the children
                    if (lc < shadow_len && outranks(shadow_heap[lc], shadow_heap[pos]))
                        best = lc;
                    if (rc < shadow_len && outranks(shadow_heap[rc], shadow_heap[best]))
                        best = rc;
                    if (best == pos) begin
                        done = 1;
                    end else begin
                        tmp = shadow_heap[pos];
                        shadow_heap[pos] = shadow_heap[best];
                        shadow_heap[best] = tmp;
                        pos = best;
                    end
                end
            end
        end else if (func == FN_READ) begin
            if (slot >= shadow_len)
                res.status = ST_RANGE;
            else
                res.slot_data = shadow_heap[slot];
        end
        res.root_key    = (shadow_len != 0) ? shadow_heap[0] : '0;
        res.entry_count = shadow_len[COUNT_W-1:0];
        return res;
    endfunction

    // stimulus helpers, gen_len follows the depth the words will produce
    task automatic queue_word(input logic [FUNC_W-1:0] func, input logic signed [31:0] key,
                              input logic [SLOT_W-1:0] slot);
        heap_word_t w;
        w.func = func;
        w.key  = key;
        w.slot = slot;
        pending_words.push_back(w);
        if (func == FN_PUSH && gen_len < HEAP_DEPTH)
            gen_len++;
        else if (func == FN_POP && gen_len > 0)
            gen_len--;
    endtask

    function automatic logic signed [31:0] rand_key();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return $urandom_range(0, 6) - 3;     // small range, many ties
        else if (pick == 2)
            return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        else
            return $urandom;
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        if (gen_len > 0 && $urandom_range(0, 3) != 0)
            return SLOT_W'($urandom_range(0, gen_len - 1));
        else
            return SLOT_W'($urandom_range(0, HEAP_DEPTH - 1));
    endfunction

    task automatic queue_random(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            queue_word(FN_PUSH, rand_key(), SLOT_W'($urandom));
        else if (r < push_pct + (100 - push_pct) * 2 / 3)
            queue_word(FN_POP, $urandom, SLOT_W'($urandom));
        else
            queue_word(FN_READ, $urandom, rand_slot());
    endtask

    // wait until every word is sent and every result is back
    task automatic wait_drained();
        while (pending_words.size() != 0 || heap_expect.size() != 0 || req_ch.valid)
            @(posedge i_clk);
    endtask

    // apb write of the order register, then read it back
    task automatic set_heap_order(input bit max_first);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ORDER_ADDR;
        pwdata  <= {{(PDATA_W-1){1'b0}}, max_first};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_max = max_first;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== max_first) begin
            $error("heap_order: expected %0d, got %0d", max_first, prdata[0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // known values on every input from time zero
    initial begin
        req_ch.valid = 1'b0;
        req_ch.func  = FN_PUSH;
        req_ch.key   = '0;
        req_ch.slot  = '0;
        rsp_ch.ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
    end

    // request driver: present the next word at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_fire) begin
            // word still waiting, hold it
        end else if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_words.size() == 0) begin
            req_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= $urandom_range(0, 3);
        end else begin
            drive_word = pending_words.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.func  <= drive_word.func;
            req_ch.key   <= drive_word.key;
            req_ch.slot  <= drive_word.slot;
        end
    end

    // accepted request words go through the shadow heap
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            heap_expect.push_back(heap_apply(req_ch.func, req_ch.key, req_ch.slot));
            status_hits[heap_expect[$].status]++;
            if (shadow_len > peak_len)
                peak_len = shadow_len;
            words_in++;
        end
    end

    // result ready: random short bursts, one long hold to back up the queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && words_out >= HOLD_AT_WORD) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // result monitor: compare against the oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            words_out++;
            if (heap_expect.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                if (rsp_ch.root_key !== heap_expect[0].root_key) begin
                    $error("root_key: expected %0d, got %0d",
                           heap_expect[0].root_key, rsp_ch.root_key);
                    mismatches++;
                end
                if (rsp_ch.entry_count !== heap_expect[0].entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           heap_expect[0].entry_count, rsp_ch.entry_count);
                    mismatches++;
                end
                if (rsp_ch.slot_data !== heap_expect[0].slot_data) begin
                    $error("slot_data: expected %0d, got %0d",
                           heap_expect[0].slot_data, rsp_ch.slot_data);
                    mismatches++;
                end
                if (rsp_ch.status !== heap_expect[0].status) begin
                    $error("status: expected %0d, got %0d",
                           heap_expect[0].status, rsp_ch.status);
                    mismatches++;
                end
                void'(heap_expect.pop_front());
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        shadow_len     = 0;
        shadow_max     = 1'b0;
        gen_len        = 0;
        mismatches     = 0;
        words_in       = 0;
        words_out      = 0;
        peak_len       = 0;
        status_hits    = '{0, 0, 0, 0};
        calm           = 1'b0;
        req_fire       = 1'b0;
        send_gap       = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        quiet_cycles   = 0;

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_heap_order(1'b0);

        // directed: empty heap, extreme keys, ties, range edges, unused code
        queue_word(FN_POP, '0, '0);
        queue_word(FN_READ, '0, '0);
        queue_word(FN_NOP, KEY_MAX, SLOT_TOP);
        queue_word(FN_PUSH, '0, '0);
        queue_word(FN_PUSH, KEY_MAX, '0);
        queue_word(FN_PUSH, KEY_MIN, '0);
        queue_word(FN_PUSH, -32'sd1, '0);
        queue_word(FN_PUSH, 32'sd1, '0);
        queue_word(FN_PUSH, 32'sd5, '0);
        queue_word(FN_PUSH, 32'sd5, '0);
        queue_word(FN_PUSH, -32'sd1, '0);
        queue_word(FN_READ, '0, 10'd0);
        queue_word(FN_READ, '0, 10'd7);
        queue_word(FN_READ, '0, 10'd8);
        queue_word(FN_READ, '0, SLOT_TOP);
        queue_word(FN_NOP, '0, '0);
        queue_word(FN_POP, '0, '0);
        queue_word(FN_POP, '0, '0);
        queue_word(FN_POP, '0, '0);
        queue_word(FN_PUSH, KEY_MIN, '0);
        queue_word(FN_READ, '0, 10'd1);
        queue_word(FN_POP, '0, '0);
        queue_word(FN_POP, '0, '0);

        // random mix, smallest key on top
        repeat (150) queue_random(60);
        wait_drained();

        // flip to largest on top with keys held
        set_heap_order(1'b1);
        repeat (150) queue_random(55);
        wait_drained();

        // fill to capacity, then push on a full heap
        set_heap_order(1'b0);
        while (gen_len < HEAP_DEPTH) begin
            if ($urandom_range(0, 15) == 0)
                queue_word(FN_READ, $urandom, rand_slot());
            else
                queue_word(FN_PUSH, rand_key(), SLOT_W'($urandom));
        end
        repeat (4) queue_word(FN_PUSH, rand_key(), SLOT_W'($urandom));
        queue_word(FN_READ, '0, SLOT_TOP);
        queue_word(FN_READ, '0, 10'd0);
        wait_drained();

        // full heap under the other order, no idling from here on
        set_heap_order(1'b1);
        calm = 1'b1;
        repeat (60) queue_random(40);
        queue_word(FN_READ, '0, SLOT_TOP);
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (heap_expect.size() != 0) begin
            $error("%0d result words never arrived", heap_expect.size());
            mismatches++;
        end
        $display("run: %0d words sent, %0d results checked, peak depth %0d",
                 words_in, words_out, peak_len);
        $display("run: %0d full pushes, %0d empty pops, %0d out-of-range reads",
                 status_hits[ST_FULL], status_hits[ST_EMPTY], status_hits[ST_RANGE]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
